/* hdl/msu_pkg.sv */
// Shared types, constants and helpers for the Metropolis spin update engine.
package msu_pkg;

  localparam int unsigned SITES_DEFAULT = 1024;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned MAX_IDX       = (2 ** IDX_W) - 1;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned RND_W         = 32;
  localparam int unsigned THR_W         = 33;
  localparam int unsigned MAG_W         = 12;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned NUM_LANES     = 4;

  // threshold of one: always accept
  localparam logic [THR_W-1:0] THR_RESET = {1'b1, {(THR_W-1){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_ONE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_THREE = 1'b1;

  // transaction modes; the spare code behaves as a read
  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  // decision handed from the merge stage to the store and output register
  typedef struct packed {
    logic wr_en;
    logic wr_data;
    logic spin;
    logic flipped;
  } msu_result_t;

  // raw index modulo sites, by conditional subtraction of shifted multiples
  function automatic logic [IDX_W-1:0] reduce_index(input logic [IDX_W-1:0] raw,
                                                    input int unsigned sites);
    logic [IDX_W:0] v;
    int unsigned    step;
    v = {1'b0, raw};
    for (int k = IDX_W - 1; k >= 0; k--) begin
      step = sites << k;
      if ((step <= MAX_IDX) && (32'(v) >= step)) begin
        v = v - (IDX_W + 1)'(step);
      end
    end
    return v[IDX_W-1:0];
  endfunction

endpackage

/* hdl/msu_lane.sv */
// One lane: index reduction and a private copy of the spin store with a registered read.
module msu_lane #(
  parameter  int unsigned SITES  = msu_pkg::SITES_DEFAULT,
  localparam int unsigned DEPTH  = (SITES < 1024) ? SITES : 1024,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [msu_pkg::IDX_W-1:0] rd_idx_i,
  input  logic                      wr_en_i,
  input  logic [ADDR_W-1:0]         wr_addr_i,
  input  logic                      wr_data_i,
  output logic [ADDR_W-1:0]         rd_addr_o,
  output logic                      rd_data_o
);
  import msu_pkg::*;

  logic              mem_q [DEPTH];
  logic [IDX_W-1:0]  idx_red;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              rd_data_q;

  // reduced index always lies below the depth
  assign idx_red = reduce_index(rd_idx_i, SITES);
  assign addr    = idx_red[ADDR_W-1:0];

  // store copy: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr];
      rd_addr_q <= addr;
    end
  end

  assign rd_addr_o = rd_addr_q;
  assign rd_data_o = rd_data_q;

endmodule

/* hdl/msu_merge.sv */
// Merge stage: counts aligned neighbours, makes the flip decision, keeps the magnetisation.
module msu_merge #(
  parameter  int unsigned SITES = msu_pkg::SITES_DEFAULT,
  localparam int unsigned TOT_W = $clog2(SITES) + 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       commit_i,
  input  logic [msu_pkg::MODE_W-1:0] mode_i,
  input  logic                       own_i,
  input  logic [2:0]                 nbr_i,
  input  logic                       spin_in_i,
  input  logic [msu_pkg::RND_W-1:0]  rnd_i,
  input  logic [msu_pkg::THR_W-1:0]  thr_one_i,
  input  logic [msu_pkg::THR_W-1:0]  thr_three_i,
  output msu_pkg::msu_result_t       res_o,
  output logic [msu_pkg::MAG_W-1:0]  mag_o
);
  import msu_pkg::*;

  localparam int unsigned EXT_W = (TOT_W > MAG_W) ? TOT_W : MAG_W;

  logic signed [TOT_W-1:0] total_q, total_d, delta;
  logic signed [EXT_W-1:0] total_ext;
  logic [2:0]              eq;
  logic [1:0]              eq_cnt;
  logic                    accept;
  msu_result_t             res;

  // neighbours that agree with the site
  assign eq     = ~(nbr_i ^ {3{own_i}});
  assign eq_cnt = 2'(eq[0]) + 2'(eq[1]) + 2'(eq[2]);

  // energy rise of one for two aligned, of three for three aligned
  always_comb begin
    if (eq_cnt < 2'd2) begin
      accept = 1'b1;
    end else if (eq_cnt == 2'd2) begin
      accept = ({1'b0, rnd_i} < thr_one_i);
    end else begin
      accept = ({1'b0, rnd_i} < thr_three_i);
    end
  end

  // per-mode store update and magnetisation step
  always_comb begin
    res     = '0;
    res.spin = own_i;
    delta   = '0;
    case (mode_e'(mode_i))
      MODE_UPDATE: begin
        res.flipped = accept;
        res.wr_en   = accept;
        res.wr_data = ~own_i;
        res.spin    = own_i ^ accept;
        if (accept) begin
          delta = own_i ? -TOT_W'(2) : TOT_W'(2);
        end
      end
      MODE_LOAD: begin
        res.wr_en   = (spin_in_i != own_i);
        res.wr_data = spin_in_i;
        res.spin    = spin_in_i;
        if (spin_in_i != own_i) begin
          delta = spin_in_i ? TOT_W'(2) : -TOT_W'(2);
        end
      end
      default: begin
        res.spin = own_i;
      end
    endcase
  end

  assign total_d = total_q + delta;

  // running magnetisation, starts with every spin at -1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOT_W'(-$signed(SITES));
    end else if (commit_i) begin
      total_q <= total_d;
    end
  end

  // wrap to the output width
  assign total_ext = EXT_W'(total_d);
  assign mag_o     = total_ext[MAG_W-1:0];
  assign res_o     = res;

`ifndef SYNTHESIS
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i |=> (total_q == $past(total_q)) || (total_q == $past(total_q) + TOT_W'(2)) ||
                 (total_q == $past(total_q) - TOT_W'(2)))
    else $error("magnetisation moved by more than one spin");
  a_flip_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.flipped |-> res.wr_en && (res.wr_data != own_i))
    else $error("flip without inverted write-back");
  a_total_matches_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && !res.wr_en |=> total_q == $past(total_q))
    else $error("magnetisation changed without a store write");
`endif

endmodule

/* hdl/metropolis_spin_update.sv */
// Top level of the Metropolis spin update engine: control, lanes, merge and output register.
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_stall_o  mode, site, three neighbours, spin, random
//  out      output     out_valid_o/out_stall_i spin_out, flipped, magnetisation_sum
//  cfg      input      cfg_wen_i              cfg_index_i, cfg_data_i (33 bit thresholds)
//
// Each transaction has a read step, reading four store copies (one per lane, site plus
// three neighbours), and a decide step, deciding and writing back to every copy.
// After reset a clearing pass over min(SITES,1024) entries zeroes the store; input is stalled.
// A finished result sits in the output register; the next transaction is accepted meanwhile
// and waits in its decide cycle only while that register is still stalled.
module metropolis_spin_update #(
  parameter int unsigned SITES = msu_pkg::SITES_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [msu_pkg::MODE_W-1:0]    mode_i,
  input  logic [msu_pkg::IDX_W-1:0]     site_index_i,
  input  logic [msu_pkg::IDX_W-1:0]     neighbour_first_i,
  input  logic [msu_pkg::IDX_W-1:0]     neighbour_second_i,
  input  logic [msu_pkg::IDX_W-1:0]     neighbour_third_i,
  input  logic                          spin_in_i,
  input  logic [msu_pkg::RND_W-1:0]     random_fraction_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          spin_out_o,
  output logic                          flipped_o,
  output logic signed [msu_pkg::MAG_W-1:0] magnetisation_sum_o,
  input  logic                          cfg_wen_i,
  input  logic [msu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [msu_pkg::THR_W-1:0]     cfg_data_i
);
  import msu_pkg::*;

  localparam int unsigned DEPTH  = (SITES < 1024) ? SITES : 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q;
  logic                clr_last;
  logic                rd_en, clr_we, commit;
  logic [THR_W-1:0]    thr_one_q, thr_three_q;
  logic [MODE_W-1:0]   mode_q;
  logic                spin_in_q;
  logic [RND_W-1:0]    rnd_q;
  logic [IDX_W-1:0]    lane_idx [NUM_LANES];
  logic [NUM_LANES-1:0] lane_data;
  logic [ADDR_W-1:0]   site_addr;
  logic                wr_en, wr_data;
  logic [ADDR_W-1:0]   wr_addr;
  msu_result_t         res;
  logic [MAG_W-1:0]    mag;
  logic                out_valid_q, spin_q, flipped_q;
  logic [MAG_W-1:0]    mag_q;

  assign clr_last = (clr_cnt_q == ADDR_W'(DEPTH - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:  if (commit) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    clr_we     = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_CLEAR: clr_we = 1'b1;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_en      = in_valid_i;
      end
      ST_EVAL:  commit = !out_valid_q || !out_stall_i;
      default:  in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (clr_we) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
    end
  end

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_one_q   <= THR_RESET;
      thr_three_q <= THR_RESET;
    end else if (cfg_wen_i) begin
      case (cfg_index_i)
        CFG_THR_ONE:   thr_one_q   <= cfg_data_i;
        CFG_THR_THREE: thr_three_q <= cfg_data_i;
        default:       thr_one_q   <= thr_one_q;
      endcase
    end
  end

  // transaction fields held for the decide cycle
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mode_q    <= mode_i;
      spin_in_q <= spin_in_i;
      rnd_q     <= random_fraction_i;
    end
  end

  // store write: clearing pass or write-back
  assign wr_en   = clr_we || (commit && res.wr_en);
  assign wr_addr = clr_we ? clr_cnt_q : site_addr;
  assign wr_data = clr_we ? 1'b0 : res.wr_data;

  assign lane_idx[0] = site_index_i;
  assign lane_idx[1] = neighbour_first_i;
  assign lane_idx[2] = neighbour_second_i;
  assign lane_idx[3] = neighbour_third_i;

  // lane 0 reads the site, the others its neighbours
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    if (g == 0) begin : g_site
      msu_lane #(.SITES(SITES)) u_lane (
        .clk_i     (clk_i),
        .rd_en_i   (rd_en),
        .rd_idx_i  (lane_idx[g]),
        .wr_en_i   (wr_en),
        .wr_addr_i (wr_addr),
        .wr_data_i (wr_data),
        .rd_addr_o (site_addr),
        .rd_data_o (lane_data[g])
      );
    end else begin : g_nbr
      msu_lane #(.SITES(SITES)) u_lane (
        .clk_i     (clk_i),
        .rd_en_i   (rd_en),
        .rd_idx_i  (lane_idx[g]),
        .wr_en_i   (wr_en),
        .wr_addr_i (wr_addr),
        .wr_data_i (wr_data),
        .rd_addr_o (),
        .rd_data_o (lane_data[g])
      );
    end
  end

  msu_merge #(.SITES(SITES)) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .commit_i    (commit),
    .mode_i      (mode_q),
    .own_i       (lane_data[0]),
    .nbr_i       (lane_data[3:1]),
    .spin_in_i   (spin_in_q),
    .rnd_i       (rnd_q),
    .thr_one_i   (thr_one_q),
    .thr_three_i (thr_three_q),
    .res_o       (res),
    .mag_o       (mag)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      spin_q    <= res.spin;
      flipped_q <= res.flipped;
      mag_q     <= mag;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign spin_out_o          = spin_q;
  assign flipped_o           = flipped_q;
  assign magnetisation_sum_o = $signed(mag_q);

`ifndef SYNTHESIS
  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_EVAL)
    else $error("accepted transaction did not enter the decide cycle");
  a_commit_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("decided transaction did not reach the output register");
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR && clr_last |=> state_q == ST_IDLE)
    else $error("clearing pass did not end after the last entry");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the Metropolis spin update engine.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msu_pkg::*;

  localparam int unsigned SITES      = SITES_DEFAULT;
  localparam logic [1:0]  MODE_SPARE = 2'd3;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          PHASES     = 8;
  localparam int          PHASE_TXNS = 230;

  // one result transaction as the engine reports it
  typedef struct packed {
    logic                    spin;
    logic                    flipped;
    logic signed [MAG_W-1:0] mag;
  } spin_result_t;

  // one step of stimulus: either a transaction or a threshold write
  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [THR_W-1:0]     cfg_val;
    logic [MODE_W-1:0]    mode;
    logic [IDX_W-1:0]     site;
    logic [IDX_W-1:0]     nb1;
    logic [IDX_W-1:0]     nb2;
    logic [IDX_W-1:0]     nb3;
    logic                 spin_in;
    logic [RND_W-1:0]     rnd;
    logic                 has_exp;
    spin_result_t         exp;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    mode = '0;
  logic [IDX_W-1:0]     site_index = '0;
  logic [IDX_W-1:0]     nb_first = '0;
  logic [IDX_W-1:0]     nb_second = '0;
  logic [IDX_W-1:0]     nb_third = '0;
  logic                 spin_in = 1'b0;
  logic [RND_W-1:0]     random_fraction = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 spin_out;
  logic                 flipped;
  logic signed [MAG_W-1:0] mag_sum;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data = '0;

  // typed expectation travelling with a directed transaction
  logic                 typed_valid = 1'b0;
  spin_result_t         typed_outcome = '0;

  // predictor state
  logic                 spin_image [SITES];
  int                   spin_sum;
  logic [THR_W-1:0]     thr_rise_one;
  logic [THR_W-1:0]     thr_rise_three;

  spin_result_t         spin_outcomes_due [$];
  stim_row_t            directed_rows [$];
  int                   mismatch_count = 0;
  int                   send_gap_pct = 0;
  int                   drain_stall_pct = 0;
  int                   quiet_cycles = 0;

  always #5 clk = ~clk;

  metropolis_spin_update dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .mode_i              (mode),
    .site_index_i        (site_index),
    .neighbour_first_i   (nb_first),
    .neighbour_second_i  (nb_second),
    .neighbour_third_i   (nb_third),
    .spin_in_i           (spin_in),
    .random_fraction_i   (random_fraction),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .spin_out_o          (spin_out),
    .flipped_o           (flipped),
    .magnetisation_sum_o (mag_sum),
    .cfg_wen_i           (cfg_wen),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  // apply one transaction to the predicted lattice; all reads see the old spins
  function automatic spin_result_t advance_lattice(
    input logic [MODE_W-1:0] op, input logic [IDX_W-1:0] site_raw,
    input logic [IDX_W-1:0] n1, input logic [IDX_W-1:0] n2,
    input logic [IDX_W-1:0] n3, input logic spin_new, input logic [RND_W-1:0] rnd);
    int           site;
    int           nb [3];
    int           equal;
    logic         own;
    logic [THR_W-1:0] thr;
    spin_result_t r;
    site  = int'(site_raw) % SITES;
    nb[0] = int'(n1) % SITES;
    nb[1] = int'(n2) % SITES;
    nb[2] = int'(n3) % SITES;
    r = '0;
    case (op)
      MODE_UPDATE: begin
        own   = spin_image[site];
        equal = 0;
        foreach (nb[k]) begin
          if (spin_image[nb[k]] == own) equal++;
        end
        // energy drop always flips; a rise flips below its threshold
        if (equal < 2) begin
          r.flipped = 1'b1;
        end else begin
          thr = (equal == 2) ? thr_rise_one : thr_rise_three;
          r.flipped = ({1'b0, rnd} < thr);
        end
        if (r.flipped) begin
          spin_sum += own ? -2 : 2;
          spin_image[site] = ~own;
        end
      end
      MODE_LOAD: begin
        if (spin_new != spin_image[site]) begin
          spin_sum += spin_new ? 2 : -2;
          spin_image[site] = spin_new;
        end
      end
      default: ;
    endcase
    r.spin = spin_image[site];
    r.mag  = spin_sum[MAG_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t txn_row(
    input logic [MODE_W-1:0] op, input int site, input int n1, input int n2, input int n3,
    input logic sp, input logic [RND_W-1:0] rnd, input logic e_spin, input logic e_flip,
    input int e_mag);
    stim_row_t t;
    t = '{default: '0};
    t.mode = op;
    t.site = IDX_W'(site);
    t.nb1 = IDX_W'(n1);
    t.nb2 = IDX_W'(n2);
    t.nb3 = IDX_W'(n3);
    t.spin_in = sp;
    t.rnd = rnd;
    t.has_exp = 1'b1;
    t.exp.spin = e_spin;
    t.exp.flipped = e_flip;
    t.exp.mag = MAG_W'(e_mag);
    return t;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [THR_W-1:0] val);
    stim_row_t t;
    t = '{default: '0};
    t.is_cfg = 1'b1;
    t.cfg_idx = idx;
    t.cfg_val = val;
    return t;
  endfunction

  // mostly a small cluster of sites so that neighbours interact
  function automatic logic [IDX_W-1:0] pick_site();
    if ($urandom_range(99) < 60) return IDX_W'($urandom_range(15));
    return IDX_W'($urandom_range(MAX_IDX));
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(4))
      0: return '0;
      1: return THR_RESET;
      2: return '1;
      default: return {1'b0, $urandom};
    endcase
  endfunction

  function automatic stim_row_t random_txn();
    stim_row_t t;
    int        pick;
    t = '{default: '0};
    pick = $urandom_range(99);
    t.mode = (pick < 60) ? MODE_UPDATE : (pick < 80) ? MODE_LOAD :
             (pick < 95) ? MODE_READ : MODE_SPARE;
    t.site = pick_site();
    t.nb1  = pick_site();
    t.nb2  = pick_site();
    t.nb3  = pick_site();
    // site listed among its own neighbours now and then
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0: t.nb1 = t.site;
        1: t.nb2 = t.site;
        default: t.nb3 = t.site;
      endcase
    end
    t.spin_in = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: t.rnd = '0;
      1: t.rnd = '1;
      2: t.rnd = thr_rise_one[RND_W-1:0] - RND_W'($urandom_range(1));
      3: t.rnd = thr_rise_three[RND_W-1:0] - RND_W'($urandom_range(1));
      default: t.rnd = $urandom;
    endcase
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // threshold write, only once every pending result is back
  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [THR_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (spin_outcomes_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // present one transaction and hold it until accepted
  task automatic send_txn(input stim_row_t t);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    mode            <= t.mode;
    site_index      <= t.site;
    nb_first        <= t.nb1;
    nb_second       <= t.nb2;
    nb_third        <= t.nb3;
    spin_in         <= t.spin_in;
    random_fraction <= t.rnd;
    typed_valid     <= t.has_exp;
    typed_outcome   <= t.exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic play_row(input stim_row_t t);
    if (t.is_cfg) write_threshold(t.cfg_idx, t.cfg_val);
    else send_txn(t);
  endtask

  // accepted input transactions feed the predictor
  always @(posedge clk) begin
    spin_result_t model;
    if (in_valid && !in_stall) begin
      model = advance_lattice(mode, site_index, nb_first, nb_second, nb_third,
                              spin_in, random_fraction);
      spin_outcomes_due.push_back(typed_valid ? typed_outcome : model);
    end
  end

  // threshold writes seen by the engine
  always @(posedge clk) begin
    if (cfg_wen) begin
      case (cfg_index)
        CFG_THR_ONE:   thr_rise_one = cfg_data;
        CFG_THR_THREE: thr_rise_three = cfg_data;
        default: ;
      endcase
    end
  end

  // accepted output transactions against the oldest expectation
  always @(posedge clk) begin
    spin_result_t want;
    if (out_valid === 1'b1 && !out_stall) begin
      if (spin_outcomes_due.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = spin_outcomes_due.pop_front();
        check_field("spin_out", int'(want.spin), int'(spin_out));
        check_field("flipped", int'(want.flipped), int'(flipped));
        check_field("magnetisation_sum", int'($signed(want.mag)), int'(mag_sum));
      end
    end
  end

  // receiver back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (drain_stall_pct > 0 && $urandom_range(99) < drain_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 1)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (spin_image[i]) spin_image[i] = 1'b0;
    spin_sum       = -int'(SITES);
    thr_rise_one   = THR_RESET;
    thr_rise_three = THR_RESET;

    // directed part; state starts all -1, total -1024
    directed_rows.push_back(txn_row(MODE_READ, 0, 0, 0, 0, 1'b0, '0, 1'b0, 1'b0, -1024));
    directed_rows.push_back(txn_row(MODE_READ, 1023, 1023, 1023, 1023, 1'b1, '1,
                                    1'b0, 1'b0, -1024));
    // spare mode acts as a read, spin_in ignored
    directed_rows.push_back(txn_row(MODE_SPARE, 512, 1, 2, 3, 1'b1, '0, 1'b0, 1'b0, -1024));
    directed_rows.push_back(txn_row(MODE_LOAD, 1023, 0, 0, 0, 1'b1, '0, 1'b1, 1'b0, -1022));
    // loading the spin already held changes nothing
    directed_rows.push_back(txn_row(MODE_LOAD, 1023, 0, 0, 0, 1'b1, '0, 1'b1, 1'b0, -1022));
    directed_rows.push_back(txn_row(MODE_LOAD, 0, 0, 0, 0, 1'b0, '1, 1'b0, 1'b0, -1022));
    // rise of three, threshold of one accepts even the top random value
    directed_rows.push_back(txn_row(MODE_UPDATE, 0, 1, 2, 3, 1'b0, '1, 1'b1, 1'b1, -1020));
    // one equal neighbour: energy drops, always flips
    directed_rows.push_back(txn_row(MODE_UPDATE, 0, 1, 2, 1023, 1'b0, '1, 1'b0, 1'b1, -1022));
    // site as all its own neighbours counts as equal
    directed_rows.push_back(txn_row(MODE_UPDATE, 0, 0, 0, 0, 1'b0, '0, 1'b1, 1'b1, -1020));
    directed_rows.push_back(txn_row(MODE_UPDATE, 1023, 1023, 0, 5, 1'b0, '1,
                                    1'b0, 1'b1, -1022));
    directed_rows.push_back(cfg_row(CFG_THR_ONE, '0));
    directed_rows.push_back(cfg_row(CFG_THR_THREE, '0));
    // zero thresholds never accept a rise
    directed_rows.push_back(txn_row(MODE_UPDATE, 2, 3, 4, 5, 1'b0, '0, 1'b0, 1'b0, -1022));
    directed_rows.push_back(txn_row(MODE_UPDATE, 1023, 1023, 0, 6, 1'b0, '0,
                                    1'b0, 1'b0, -1022));
    directed_rows.push_back(cfg_row(CFG_THR_ONE, 33'h0_FFFF_FFFF));
    // acceptance is strictly below the threshold
    directed_rows.push_back(txn_row(MODE_UPDATE, 1023, 1023, 0, 6, 1'b0, 32'hFFFF_FFFF,
                                    1'b0, 1'b0, -1022));
    directed_rows.push_back(txn_row(MODE_UPDATE, 1023, 1023, 0, 6, 1'b0, 32'hFFFF_FFFE,
                                    1'b1, 1'b1, -1020));
    directed_rows.push_back(cfg_row(CFG_THR_THREE, 33'd1));
    directed_rows.push_back(txn_row(MODE_UPDATE, 2, 3, 4, 5, 1'b0, '0, 1'b1, 1'b1, -1018));
    directed_rows.push_back(txn_row(MODE_UPDATE, 2, 3, 4, 5, 1'b0, 32'd1, 1'b0, 1'b1, -1020));
    directed_rows.push_back(txn_row(MODE_LOAD, 512, 0, 0, 0, 1'b1, '0, 1'b1, 1'b0, -1018));
    directed_rows.push_back(txn_row(MODE_READ, 512, 0, 0, 0, 1'b0, '0, 1'b1, 1'b0, -1018));
    directed_rows.push_back(txn_row(MODE_LOAD, 512, 0, 0, 0, 1'b0, '0, 1'b0, 1'b0, -1020));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) play_row(directed_rows[i]);

    // random phases, each under new thresholds, most with input gaps or output stalls; the last one runs flat out
    for (int ph = 0; ph < PHASES; ph++) begin
      write_threshold(CFG_THR_ONE, pick_threshold());
      write_threshold(CFG_THR_THREE, pick_threshold());
      if (ph == PHASES - 1) begin
        send_gap_pct    = 0;
        drain_stall_pct = 0;
      end else begin
        send_gap_pct    = (ph % 3 == 0) ? 0 : $urandom_range(60);
        drain_stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(60);
      end
      repeat (PHASE_TXNS) send_txn(random_txn());
    end

    in_valid <= 1'b0;
    while (spin_outcomes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
